[rtl/core/tcw_pkg.sv]
// Shared constants, codes and types of the text console cell writer.
package tcw_pkg;

	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int CELLS  = COLS * ROWS;
	localparam int CELL_W = $clog2(CELLS);

	localparam logic [7:0] NL_CODE    = 8'h0A;
	localparam logic [7:0] ERR_CODE   = 8'h45;
	localparam logic [7:0] SPACE_CODE = 8'h20;

	localparam logic [1:0] FUNC_PUT   = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic REG_DEFAULT_ATTR = 1'b0;
	localparam logic REG_ERROR_ATTR   = 1'b1;

	localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;
	localparam logic [7:0] ERROR_ATTR_RST   = 8'd244;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_ADDR,
		S_ACT,
		S_RD_WAIT,
		S_CLEAR,
		S_SCR_RD0,
		S_SCR_MV,
		S_SCR_ZERO,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic [CELL_W-1:0] waddr;
		logic [15:0]       wdata;
		logic              re;
		logic [CELL_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic [7:0] default_attr;
		logic [7:0] error_attr;
	} cfg_t;

endpackage

[rtl/core/tcw_screen_ram.sv]
// Screen cell store: one write port and one registered read port.
module tcw_screen_ram (
	input  logic              clk,
	input  tcw_pkg::ram_req_t req,
	output logic [15:0]       rdata
);

	logic [15:0] mem_q [tcw_pkg::CELLS];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/tcw_cfg.sv]
// APB configuration registers: default and error attributes.
module tcw_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output tcw_pkg::cfg_t cfg
);

	logic [7:0] default_attr_q;
	logic [7:0] error_attr_q;
	logic       wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= tcw_pkg::DEFAULT_ATTR_RST;
			error_attr_q   <= tcw_pkg::ERROR_ATTR_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				tcw_pkg::REG_DEFAULT_ATTR: default_attr_q <= pwdata[7:0];
				tcw_pkg::REG_ERROR_ATTR:   error_attr_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			tcw_pkg::REG_DEFAULT_ATTR: prdata = {24'd0, default_attr_q};
			tcw_pkg::REG_ERROR_ATTR:   prdata = {24'd0, error_attr_q};
			default:                   prdata = 32'd0;
		endcase
	end

	assign cfg.default_attr = default_attr_q;
	assign cfg.error_attr   = error_attr_q;

endmodule

[rtl/core/tcw_seq.sv]
// Sequencer: cursor, address unit, sweep counter and store accesses.
module tcw_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        func,
	input  logic [7:0]        char_code,
	input  logic [7:0]        attribute,
	input  logic              use_cursor,
	input  logic [6:0]        column,
	input  logic [4:0]        row_index,
	input  tcw_pkg::cfg_t     cfg,
	input  logic [15:0]       rdata,
	output logic              busy,
	output logic              done,
	output logic [6:0]        cursor_column,
	output logic [4:0]        cursor_row,
	output logic              error,
	output logic              scrolled,
	output logic [7:0]        cell_char,
	output logic [7:0]        cell_attribute,
	output tcw_pkg::ram_req_t ram
);

	localparam int CW = tcw_pkg::CELL_W;

	tcw_pkg::state_t state_q, state_d;

	logic [1:0]    func_q;
	logic [7:0]    ch_q;
	logic [7:0]    at_q;
	logic          usec_q;
	logic [6:0]    col_q;
	logic [4:0]    row_q;
	logic [6:0]    cur_col_q;
	logic [4:0]    cur_row_q;
	logic [CW-1:0] addr_q;
	logic          bad_q;
	logic [CW-1:0] sweep_q;
	logic          err_q;
	logic          scr_q;
	logic [7:0]    rch_q;
	logic [7:0]    rat_q;

	logic          at_cur;
	logic [6:0]    tcol;
	logic [4:0]    trow;
	logic [CW-1:0] addr_d;
	logic          bad_d;
	logic          is_put;
	logic          is_nl;
	logic          last_col;
	logic          last_row;
	logic          scroll_d;
	logic          sweep_last;
	logic          mv_last;

	assign at_cur = (func_q == tcw_pkg::FUNC_PUT) && usec_q;
	assign tcol   = at_cur ? cur_col_q : col_q;
	assign trow   = at_cur ? cur_row_q : row_q;
	assign addr_d = CW'(trow) * CW'(tcw_pkg::COLS) + CW'(tcol);
	assign bad_d  = !at_cur && ((8'(col_q) >= 8'(tcw_pkg::COLS)) ||
		(6'(row_q) >= 6'(tcw_pkg::ROWS)));

	assign is_put     = (func_q == tcw_pkg::FUNC_PUT);
	assign is_nl      = (ch_q == tcw_pkg::NL_CODE);
	assign last_col   = (8'(col_q) == 8'(tcw_pkg::COLS - 1));
	assign last_row   = (6'(row_q) == 6'(tcw_pkg::ROWS - 1));
	assign scroll_d   = is_put && !bad_q && last_row && (is_nl || last_col);
	assign sweep_last = (sweep_q == CW'(tcw_pkg::CELLS - 1));
	assign mv_last    = (sweep_q == CW'(tcw_pkg::CELLS - tcw_pkg::COLS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::S_INIT: begin
				if (sweep_last) begin
					state_d = tcw_pkg::S_IDLE;
				end
			end
			tcw_pkg::S_IDLE: begin
				if (start) begin
					state_d = tcw_pkg::S_ADDR;
				end
			end
			tcw_pkg::S_ADDR: state_d = tcw_pkg::S_ACT;
			tcw_pkg::S_ACT: begin
				unique case (func_q)
					tcw_pkg::FUNC_PUT:
						state_d = scroll_d ? tcw_pkg::S_SCR_RD0 : tcw_pkg::S_DONE;
					tcw_pkg::FUNC_CLEAR: state_d = tcw_pkg::S_CLEAR;
					tcw_pkg::FUNC_READ:
						state_d = bad_q ? tcw_pkg::S_DONE : tcw_pkg::S_RD_WAIT;
					default: state_d = tcw_pkg::S_DONE;
				endcase
			end
			tcw_pkg::S_RD_WAIT: state_d = tcw_pkg::S_DONE;
			tcw_pkg::S_CLEAR: begin
				if (sweep_last) begin
					state_d = tcw_pkg::S_DONE;
				end
			end
			tcw_pkg::S_SCR_RD0: state_d = tcw_pkg::S_SCR_MV;
			tcw_pkg::S_SCR_MV: begin
				if (mv_last) begin
					state_d = tcw_pkg::S_SCR_ZERO;
				end
			end
			tcw_pkg::S_SCR_ZERO: begin
				if (sweep_last) begin
					state_d = tcw_pkg::S_DONE;
				end
			end
			tcw_pkg::S_DONE: state_d = tcw_pkg::S_IDLE;
			default: state_d = tcw_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ram.we    = 1'b0;
		ram.waddr = sweep_q;
		ram.wdata = 16'd0;
		ram.re    = 1'b0;
		ram.raddr = addr_q;
		unique case (state_q)
			tcw_pkg::S_INIT: ram.we = 1'b1;
			tcw_pkg::S_ACT: begin
				if (is_put && bad_q) begin
					ram.we    = 1'b1;
					ram.waddr = CW'(tcw_pkg::CELLS - 1);
					ram.wdata = {cfg.error_attr, tcw_pkg::ERR_CODE};
				end else if (is_put && !is_nl) begin
					ram.we    = 1'b1;
					ram.waddr = addr_q;
					ram.wdata = {(at_q == 8'd0) ? cfg.default_attr : at_q, ch_q};
				end else if ((func_q == tcw_pkg::FUNC_READ) && !bad_q) begin
					ram.re = 1'b1;
				end
			end
			tcw_pkg::S_CLEAR: begin
				ram.we    = 1'b1;
				ram.wdata = {cfg.default_attr, tcw_pkg::SPACE_CODE};
			end
			tcw_pkg::S_SCR_RD0: begin
				ram.re    = 1'b1;
				ram.raddr = CW'(tcw_pkg::COLS);
			end
			tcw_pkg::S_SCR_MV: begin
				ram.we    = 1'b1;
				ram.wdata = rdata;
				ram.re    = !mv_last;
				ram.raddr = sweep_q + CW'(tcw_pkg::COLS + 1);
			end
			tcw_pkg::S_SCR_ZERO: ram.we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tcw_pkg::S_INIT;
			sweep_q   <= '0;
			cur_col_q <= '0;
			cur_row_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				tcw_pkg::S_INIT, tcw_pkg::S_CLEAR, tcw_pkg::S_SCR_MV,
				tcw_pkg::S_SCR_ZERO: sweep_q <= sweep_q + CW'(1);
				tcw_pkg::S_ACT: begin
					sweep_q <= '0;
					if (func_q == tcw_pkg::FUNC_CLEAR) begin
						cur_col_q <= '0;
						cur_row_q <= '0;
					end else if (is_put && !bad_q) begin
						if (is_nl || last_col) begin
							cur_col_q <= '0;
							cur_row_q <= last_row ? row_q : row_q + 5'd1;
						end else begin
							cur_col_q <= col_q + 7'd1;
							cur_row_q <= row_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tcw_pkg::S_IDLE: begin
				if (start) begin
					func_q <= func;
					ch_q   <= char_code;
					at_q   <= attribute;
					usec_q <= use_cursor;
					col_q  <= column;
					row_q  <= row_index;
					err_q  <= 1'b0;
					scr_q  <= 1'b0;
					rch_q  <= 8'd0;
					rat_q  <= 8'd0;
				end
			end
			tcw_pkg::S_ADDR: begin
				addr_q <= addr_d;
				bad_q  <= bad_d;
				col_q  <= tcol;
				row_q  <= trow;
			end
			tcw_pkg::S_ACT: begin
				err_q <= bad_q && (is_put || (func_q == tcw_pkg::FUNC_READ));
				scr_q <= scroll_d;
			end
			tcw_pkg::S_RD_WAIT: begin
				rch_q <= rdata[7:0];
				rat_q <= rdata[15:8];
			end
			default: ;
		endcase
	end

	assign busy           = (state_q != tcw_pkg::S_IDLE);
	assign done           = (state_q == tcw_pkg::S_DONE);
	assign cursor_column  = cur_col_q;
	assign cursor_row     = cur_row_q;
	assign error          = err_q;
	assign scrolled       = scr_q;
	assign cell_char      = rch_q;
	assign cell_attribute = rat_q;

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after a result");

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transaction accepted but block not busy");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(8'(cur_col_q) < 8'(tcw_pkg::COLS)) && (6'(cur_row_q) < 6'(tcw_pkg::ROWS)))
		else $error("cursor outside the screen");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(done && scrolled) |-> ((cur_col_q == 7'd0) &&
		(6'(cur_row_q) == 6'(tcw_pkg::ROWS - 1))))
		else $error("cursor not at start of last row after scroll");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram.we |-> ((CW + 1)'(ram.waddr) < (CW + 1)'(tcw_pkg::CELLS)))
		else $error("store write beyond last cell");

endmodule

[rtl/core/text_console_cell_writer.sv]
// Top level of the text console cell writer.
// One transaction is accepted when start is high and busy is low; its result appears for
// exactly one cycle with done high and cannot be held off, so take it on that edge. A put,
// a bad-coordinate read or an unused function code goes through the address and act states
// to done, a good read also through a read-wait state, and busy drops the cycle after done.
// A put that runs past the last row scrolls, and a clear fills the screen: each writes every
// cell once through the cell store, one write a cycle; a scroll also reads each cell that it
// moves up a row. After reset, busy stays high while the store is cleared; configuration
// writes are taken meanwhile.
module text_console_cell_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attribute,
	input  logic        use_cursor,
	input  logic [6:0]  column,
	input  logic [4:0]  row_index,
	output logic        done,
	output logic [6:0]  cursor_column,
	output logic [4:0]  cursor_row,
	output logic        error,
	output logic        scrolled,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attribute,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	tcw_pkg::cfg_t     cfg;
	tcw_pkg::ram_req_t ram;
	logic [15:0]       rdata;

	tcw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcw_screen_ram u_ram (
		.clk   (clk),
		.req   (ram),
		.rdata (rdata)
	);

	tcw_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.func           (func),
		.char_code      (char_code),
		.attribute      (attribute),
		.use_cursor     (use_cursor),
		.column         (column),
		.row_index      (row_index),
		.cfg            (cfg),
		.rdata          (rdata),
		.busy           (busy),
		.done           (done),
		.cursor_column  (cursor_column),
		.cursor_row     (cursor_row),
		.error          (error),
		.scrolled       (scrolled),
		.cell_char      (cell_char),
		.cell_attribute (cell_attribute),
		.ram            (ram)
	);

endmodule

[verif/text_console_cell_writer_tb.sv]
// Self-checking testbench of the text console cell writer: directed and random command traffic.
module text_console_cell_writer_tb;

	localparam logic [1:0] FUNC_NONE      = 2'd3;
	localparam int         WATCHDOG_LIMIT = 12000;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] char_code;
		logic [7:0] attribute;
		logic       use_cursor;
		logic [6:0] column;
		logic [4:0] row_index;
	} console_cmd_t;

	typedef struct packed {
		logic [6:0] cursor_column;
		logic [4:0] cursor_row;
		logic       error;
		logic       scrolled;
		logic [7:0] cell_char;
		logic [7:0] cell_attribute;
	} console_res_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic        busy;
	logic [1:0]  func       = tcw_pkg::FUNC_PUT;
	logic [7:0]  char_code  = '0;
	logic [7:0]  attribute  = '0;
	logic        use_cursor = 1'b0;
	logic [6:0]  column     = '0;
	logic [4:0]  row_index  = '0;
	logic        done;
	logic [6:0]  cursor_column;
	logic [4:0]  cursor_row;
	logic        error;
	logic        scrolled;
	logic [7:0]  cell_char;
	logic [7:0]  cell_attribute;
	logic        psel       = 1'b0;
	logic        penable    = 1'b0;
	logic        pwrite     = 1'b0;
	logic [2:0]  paddr      = '0;
	logic [31:0] pwdata     = '0;
	logic [31:0] prdata;
	logic        pready;

	logic [15:0]  cell_store [tcw_pkg::CELLS] = '{default: 16'h0000};
	int           cursor_pos = 0;
	logic [7:0]   dflt_attr  = tcw_pkg::DEFAULT_ATTR_RST;
	logic [7:0]   err_attr   = tcw_pkg::ERROR_ATTR_RST;
	console_res_t pending_results [$];
	int           failures    = 0;
	int           stall_count = 0;
	bit           idle_on     = 1'b1;

	text_console_cell_writer i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.char_code      (char_code),
		.attribute      (attribute),
		.use_cursor     (use_cursor),
		.column         (column),
		.row_index      (row_index),
		.done           (done),
		.cursor_column  (cursor_column),
		.cursor_row     (cursor_row),
		.error          (error),
		.scrolled       (scrolled),
		.cell_char      (cell_char),
		.cell_attribute (cell_attribute),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic console_res_t console_apply(console_cmd_t c);
		console_res_t r;
		int           pos;
		logic         bad;
		logic [7:0]   at;
		r   = '0;
		bad = (c.column >= tcw_pkg::COLS) || (c.row_index >= tcw_pkg::ROWS);
		case (c.func)
			tcw_pkg::FUNC_PUT: begin
				if (!c.use_cursor && bad) begin
					cell_store[tcw_pkg::CELLS-1] = {err_attr, tcw_pkg::ERR_CODE};
					r.error = 1'b1;
				end else begin
					pos = c.use_cursor ? cursor_pos :
						int'(c.row_index) * tcw_pkg::COLS + int'(c.column);
					if (pos >= tcw_pkg::CELLS)
						pos = 0;
					if (c.char_code == tcw_pkg::NL_CODE) begin
						pos = (pos / tcw_pkg::COLS + 1) * tcw_pkg::COLS;
					end else begin
						at = (c.attribute == 8'd0) ? dflt_attr : c.attribute;
						cell_store[pos] = {at, c.char_code};
						pos++;
					end
					if (pos >= tcw_pkg::CELLS) begin
						for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLS; i++)
							cell_store[i] = cell_store[i + tcw_pkg::COLS];
						for (int i = tcw_pkg::CELLS - tcw_pkg::COLS; i < tcw_pkg::CELLS; i++)
							cell_store[i] = 16'h0000;
						pos -= tcw_pkg::COLS;
						r.scrolled = 1'b1;
					end
					cursor_pos = pos;
				end
			end
			tcw_pkg::FUNC_CLEAR: begin
				for (int i = 0; i < tcw_pkg::CELLS; i++)
					cell_store[i] = {dflt_attr, tcw_pkg::SPACE_CODE};
				cursor_pos = 0;
			end
			tcw_pkg::FUNC_READ: begin
				if (bad) begin
					r.error = 1'b1;
				end else begin
					pos = int'(c.row_index) * tcw_pkg::COLS + int'(c.column);
					r.cell_char      = cell_store[pos][7:0];
					r.cell_attribute = cell_store[pos][15:8];
				end
			end
			default: ;
		endcase
		r.cursor_column = 7'(cursor_pos % tcw_pkg::COLS);
		r.cursor_row    = 5'(cursor_pos / tcw_pkg::COLS);
		return r;
	endfunction

	function automatic console_cmd_t cmd_of(logic [1:0] f, logic [7:0] ch, logic [7:0] at,
		logic uc, logic [6:0] col, logic [4:0] row);
		return '{f, ch, at, uc, col, row};
	endfunction

	function automatic console_cmd_t random_cmd();
		console_cmd_t c;
		int           pick;
		pick         = $urandom_range(0, 99);
		c.char_code  = 8'($urandom_range(0, 255));
		c.attribute  = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
		c.use_cursor = 1'($urandom_range(0, 1));
		c.column     = 7'($urandom_range(0, 127));
		c.row_index  = 5'($urandom_range(0, 31));
		if ($urandom_range(0, 9) != 0) begin
			c.column    = 7'($urandom_range(0, tcw_pkg::COLS - 1));
			c.row_index = 5'($urandom_range(0, tcw_pkg::ROWS - 1));
		end
		if (pick < 65) begin
			c.func       = tcw_pkg::FUNC_PUT;
			c.use_cursor = ($urandom_range(0, 4) < 3);
			if ($urandom_range(0, 9) == 0)
				c.char_code = tcw_pkg::NL_CODE;
			if (!c.use_cursor && $urandom_range(0, 9) == 0)
				c.row_index = 5'(tcw_pkg::ROWS - 1);
		end else if (pick < 67) begin
			c.func = tcw_pkg::FUNC_CLEAR;
		end else if (pick < 97) begin
			c.func = tcw_pkg::FUNC_READ;
		end else begin
			c.func = FUNC_NONE;
		end
		return c;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		console_res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no transaction outstanding");
				failures++;
			end else begin
				want = pending_results.pop_front();
				check_field("cursor_column", 32'(want.cursor_column), 32'(cursor_column));
				check_field("cursor_row", 32'(want.cursor_row), 32'(cursor_row));
				check_field("error", 32'(want.error), 32'(error));
				check_field("scrolled", 32'(want.scrolled), 32'(scrolled));
				check_field("cell_char", 32'(want.cell_char), 32'(cell_char));
				check_field("cell_attribute", 32'(want.cell_attribute),
					32'(cell_attribute));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= WATCHDOG_LIMIT) begin
			$display("text_console_cell_writer_tb NOT OK");
			$finish;
		end
	end

	task automatic send_cmd(input console_cmd_t c);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start      <= 1'b1;
		func       <= c.func;
		char_code  <= c.char_code;
		attribute  <= c.attribute;
		use_cursor <= c.use_cursor;
		column     <= c.column;
		row_index  <= c.row_index;
		do @(posedge clk); while (busy);
		pending_results.push_back(console_apply(c));
	endtask

	// hold off until every outstanding transaction has completed
	task automatic drain_results();
		if (start)
			start <= 1'b0;
		while (busy || pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic reg_write(input logic reg_sel, input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == tcw_pkg::REG_DEFAULT_ATTR)
			dflt_attr = value;
		else
			err_attr = value;
	endtask

	task automatic test_reset_state();
		send_cmd(cmd_of(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0));
		send_cmd(cmd_of(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 1'b0, 7'(tcw_pkg::COLS - 1),
			5'(tcw_pkg::ROWS - 1)));
	endtask

	task automatic test_put_and_scroll();
		send_cmd(cmd_of(tcw_pkg::FUNC_PUT, 8'h41, 8'h00, 1'b0, 7'd0, 5'd0));
		send_cmd(cmd_of(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0));
		send_cmd(cmd_of(tcw_pkg::FUNC_PUT, 8'hFF, 8'hFF, 1'b0, 7'(tcw_pkg::COLS - 1),
			5'(tcw_pkg::ROWS - 1)));
		send_cmd(cmd_of(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 1'b0, 7'(tcw_pkg::COLS - 1),
			5'(tcw_pkg::ROWS - 2)));
		send_cmd(cmd_of(tcw_pkg::FUNC_PUT, 8'h00, 8'h01, 1'b1, 7'd0, 5'd0));
	endtask

	task automatic test_bad_coordinates();
		send_cmd(cmd_of(tcw_pkg::FUNC_PUT, 8'h31, 8'h22, 1'b0, 7'(tcw_pkg::COLS), 5'd0));
		send_cmd(cmd_of(tcw_pkg::FUNC_PUT, 8'h32, 8'h00, 1'b0, 7'd127, 5'd31));
		send_cmd(cmd_of(tcw_pkg::FUNC_PUT, 8'h33, 8'h44, 1'b0, 7'd0, 5'(tcw_pkg::ROWS)));
		send_cmd(cmd_of(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 1'b0, 7'(tcw_pkg::COLS - 1),
			5'(tcw_pkg::ROWS - 1)));
		send_cmd(cmd_of(tcw_pkg::FUNC_READ, 8'hFF, 8'hFF, 1'b1, 7'(tcw_pkg::COLS), 5'd5));
		send_cmd(cmd_of(tcw_pkg::FUNC_PUT, 8'h78, 8'h5A, 1'b1, 7'd127, 5'd31));
	endtask

	task automatic test_newline();
		send_cmd(cmd_of(tcw_pkg::FUNC_PUT, tcw_pkg::NL_CODE, 8'h00, 1'b0, 7'd5, 5'd10));
		send_cmd(cmd_of(tcw_pkg::FUNC_PUT, tcw_pkg::NL_CODE, 8'h07, 1'b0, 7'd0,
			5'(tcw_pkg::ROWS - 1)));
		send_cmd(cmd_of(tcw_pkg::FUNC_PUT, tcw_pkg::NL_CODE, 8'h00, 1'b1, 7'd0, 5'd0));
	endtask

	task automatic test_clear_and_unused_func();
		send_cmd(cmd_of(FUNC_NONE, 8'hFF, 8'hFF, 1'b1, 7'd127, 5'd31));
		send_cmd(cmd_of(tcw_pkg::FUNC_CLEAR, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0));
		send_cmd(cmd_of(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 1'b0, 7'd40, 5'd12));
		send_cmd(cmd_of(tcw_pkg::FUNC_PUT, 8'h7A, 8'h00, 1'b1, 7'd0, 5'd0));
	endtask

	task automatic test_register_extremes();
		logic [7:0] levels [2] = '{8'h00, 8'hFF};
		foreach (levels[k]) begin
			drain_results();
			reg_write(tcw_pkg::REG_DEFAULT_ATTR, levels[k]);
			reg_write(tcw_pkg::REG_ERROR_ATTR, levels[k]);
			send_cmd(cmd_of(tcw_pkg::FUNC_PUT, 8'h61, 8'h00, 1'b1, 7'd0, 5'd0));
			send_cmd(cmd_of(tcw_pkg::FUNC_PUT, 8'h62, 8'h00, 1'b0, 7'd100, 5'd3));
			send_cmd(cmd_of(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 1'b0, 7'(tcw_pkg::COLS - 1),
				5'(tcw_pkg::ROWS - 1)));
		end
	endtask

	task automatic test_random_traffic(input int phases, input int per_phase);
		logic [7:0] v [2];
		for (int p = 0; p < phases; p++) begin
			drain_results();
			foreach (v[k]) begin
				case ($urandom_range(0, 3))
					0:       v[k] = 8'h00;
					1:       v[k] = 8'hFF;
					default: v[k] = 8'($urandom_range(0, 255));
				endcase
			end
			reg_write(tcw_pkg::REG_DEFAULT_ATTR, v[0]);
			reg_write(tcw_pkg::REG_ERROR_ATTR, v[1]);
			for (int n = 0; n < per_phase; n++) begin
				if (idle_on && $urandom_range(0, 59) == 0)
					drain_results();
				send_cmd(random_cmd());
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_put_and_scroll();
		test_bad_coordinates();
		test_newline();
		test_clear_and_unused_func();
		test_register_extremes();
		test_random_traffic(4, 160);
		idle_on = 1'b0;
		test_random_traffic(1, 160);
		drain_results();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("text_console_cell_writer_tb OK");
		else
			$display("text_console_cell_writer_tb NOT OK");
		$finish;
	end

endmodule
